### hw/rtl/heq_pkg.sv
// ----------------------------------------------------------------------------
// heq_pkg: shared definitions for the histogram equalizer
// Command codes, sequencer states and divider states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package heq_pkg;

    // input command codes
    localparam logic [1:0] CMD_COUNT = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_MAP   = 2'd2;

    // main sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_UPD,
        ST_MAP_RESP,
        ST_BLD_RD,
        ST_BLD_ACC,
        ST_BLD_MUL,
        ST_BLD_DIV,
        ST_BLD_WR,
        ST_BLD_RESP
    } heq_state_t;

    // shared divider states
    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

endpackage

`default_nettype wire

### hw/rtl/heq_divider.sv
// ----------------------------------------------------------------------------
// heq_divider: iterative shift-subtract divider
// Produces QUO_W quotient bits, one per cycle. The caller guarantees
// num < den * 2^QUO_W and den * 2^(QUO_W-1) fits in W bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module heq_divider #(
    parameter int W     = 26,
    parameter int QUO_W = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [W-1:0]     num,
    input  wire logic [W-1:0]     den,
    output logic                  done,
    output logic [QUO_W-1:0]      quo
);
    import heq_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    div_state_t       state_reg, state_next;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dsh_reg;
    logic [QUO_W-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             ge;
    logic             last;

    // shared compare/subtract step
    assign ge   = (rem_reg >= dsh_reg);
    assign last = (cnt_reg == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: if (start) state_next = DIV_RUN;
            DIV_RUN:  if (last) state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    // outputs: final quotient bit merged in on the done cycle
    always_comb begin
        done = (state_reg == DIV_RUN) && last;
        quo  = QUO_W'({q_reg, ge});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == DIV_IDLE) begin
            if (start) begin
                rem_reg <= num;
                dsh_reg <= den << (QUO_W - 1);
                q_reg   <= '0;
                cnt_reg <= CNT_W'(QUO_W - 1);
            end
        end else begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= QUO_W'({q_reg, ge});
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/histogram_equalizer_top.sv
// ----------------------------------------------------------------------------
// histogram_equalizer_top: 8-bit grey histogram equalization
// Count, build and map commands over a bin memory and a mapping table memory.
// ----------------------------------------------------------------------------
// count: no result (bin memory read-modify-write in ST_CNT_UPD), then back to ST_IDLE
// map: table read, then result register loaded in ST_MAP_RESP once m_ready or empty
// build: per bin ST_BLD_RD, ST_BLD_ACC, ST_BLD_MUL, ST_BLD_DIV and ST_BLD_WR, the shared
//   divider at one quotient bit per cycle; a bin needing no division skips ST_BLD_DIV
// reset: synchronous active low; then ST_CLEAR writes zero to every entry of the bin
//   memory, no input accepted meanwhile
`timescale 1ns / 1ps
`default_nettype none

module histogram_equalizer_top #(
    parameter int GREY_LEVELS = 256,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_cmd,
    input  wire logic [7:0] s_pixel,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_mapped_pixel,
    output logic            m_table_built
);
    import heq_pkg::*;

    localparam int IDX_W = $clog2(GREY_LEVELS);
    localparam int CUM_W = COUNT_BITS + IDX_W;
    localparam int DIV_W = COUNT_BITS + IDX_W + 2;
    localparam logic [IDX_W-1:0]      TOP       = IDX_W'(GREY_LEVELS - 1);
    localparam logic [IDX_W:0]        TWO_TOP   = (IDX_W + 1)'(2 * (GREY_LEVELS - 1));
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    heq_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] bin_mem [GREY_LEVELS];
    logic [IDX_W-1:0]      tbl_mem [GREY_LEVELS];

    logic [COUNT_BITS-1:0] bin_rdata_reg;
    logic [IDX_W-1:0]      tbl_rdata_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [CUM_W-1:0]      cum_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      pix_reg;
    logic [IDX_W-1:0]      entry_reg;
    logic                  m_valid_reg;
    logic [7:0]            m_mapped_pixel_reg;
    logic                  m_table_built_reg;

    logic                  accept;
    logic                  out_free;
    logic                  idx_last;
    logic [IDX_W-1:0]      pix_idx;
    logic                  bin_re;
    logic                  bin_we;
    logic [IDX_W-1:0]      bin_addr;
    logic [COUNT_BITS-1:0] bin_wdata;
    logic                  tbl_re;
    logic                  tbl_we;
    logic [IDX_W-1:0]      tbl_addr;
    logic                  div_start;
    logic                  div_done;
    logic [IDX_W-1:0]      div_quo;
    logic [DIV_W-1:0]      div_num;
    logic [DIV_W-1:0]      div_den;
    logic                  tot_zero;
    logic                  cum_over;
    logic                  out_load;

    // clamp pixel to the bin range
    assign pix_idx  = ({1'b0, s_pixel} > 9'(GREY_LEVELS - 1)) ? TOP : IDX_W'(s_pixel);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_last = (idx_reg == TOP);

    // numerator and divisor of the rounded cdf scaling
    assign div_num  = DIV_W'(cum_reg[COUNT_BITS-1:0]) * DIV_W'(TWO_TOP) + DIV_W'(total_reg);
    assign div_den  = DIV_W'({total_reg, 1'b0});
    assign tot_zero = (total_reg == '0);
    assign cum_over = (cum_reg > CUM_W'(total_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (idx_last) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    case (s_cmd)
                        CMD_COUNT: state_next = ST_CNT_UPD;
                        CMD_BUILD: state_next = ST_BLD_RD;
                        CMD_MAP:   state_next = ST_MAP_RESP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CNT_UPD:  state_next = ST_IDLE;
            ST_MAP_RESP: if (out_free) state_next = ST_IDLE;
            ST_BLD_RD:   state_next = ST_BLD_ACC;
            ST_BLD_ACC:  state_next = ST_BLD_MUL;
            ST_BLD_MUL: begin
                if (tot_zero || cum_over) state_next = ST_BLD_WR;
                else state_next = ST_BLD_DIV;
            end
            ST_BLD_DIV:  if (div_done) state_next = ST_BLD_WR;
            ST_BLD_WR: begin
                if (idx_last) state_next = ST_BLD_RESP;
                else state_next = ST_BLD_RD;
            end
            ST_BLD_RESP: if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        bin_re    = 1'b0;
        bin_we    = 1'b0;
        bin_addr  = idx_reg;
        bin_wdata = '0;
        tbl_re    = 1'b0;
        tbl_we    = 1'b0;
        tbl_addr  = idx_reg;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                bin_we = 1'b1;
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                bin_addr = pix_idx;
                tbl_addr = pix_idx;
                bin_re   = s_valid && (s_cmd == CMD_COUNT);
                tbl_re   = s_valid && (s_cmd == CMD_MAP);
            end
            ST_CNT_UPD: begin
                bin_addr  = pix_reg;
                bin_we    = 1'b1;
                bin_wdata = (bin_rdata_reg == COUNT_MAX) ? bin_rdata_reg
                                                         : bin_rdata_reg + 1'b1;
            end
            ST_MAP_RESP: out_load = out_free;
            ST_BLD_RD:   bin_re = 1'b1;
            ST_BLD_ACC:  bin_we = 1'b1;
            ST_BLD_MUL:  div_start = !(tot_zero || cum_over);
            ST_BLD_DIV:  ;
            ST_BLD_WR:   tbl_we = 1'b1;
            ST_BLD_RESP: out_load = out_free;
            default:     ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // bin memory
    always_ff @(posedge aclk) begin
        if (bin_we) begin
            bin_mem[bin_addr] <= bin_wdata;
        end
        if (bin_re) begin
            bin_rdata_reg <= bin_mem[bin_addr];
        end
    end

    // mapping table memory
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_addr] <= entry_reg;
        end
        if (tbl_re) begin
            tbl_rdata_reg <= tbl_mem[tbl_addr];
        end
    end

    // shared divider
    heq_divider #(
        .W     (DIV_W),
        .QUO_W (IDX_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // bin index and pixel total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            total_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: idx_reg <= idx_reg + 1'b1;
                ST_IDLE: begin
                    if (accept && (s_cmd == CMD_BUILD)) begin
                        idx_reg <= '0;
                    end
                end
                ST_CNT_UPD: begin
                    if (total_reg != COUNT_MAX) begin
                        total_reg <= total_reg + 1'b1;
                    end
                end
                ST_BLD_WR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_last) begin
                        total_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // build and count payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            pix_reg <= pix_idx;
            cum_reg <= '0;
        end
        if (state_reg == ST_BLD_ACC) begin
            cum_reg <= cum_reg + CUM_W'(bin_rdata_reg);
        end
        if (state_reg == ST_BLD_MUL) begin
            entry_reg <= tot_zero ? '0 : TOP;
        end
        if (div_done) begin
            entry_reg <= div_quo;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (state_reg == ST_MAP_RESP) begin
                m_mapped_pixel_reg <= 8'(tbl_rdata_reg);
                m_table_built_reg  <= 1'b0;
            end else begin
                m_mapped_pixel_reg <= '0;
                m_table_built_reg  <= 1'b1;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mapped_pixel = m_mapped_pixel_reg;
    assign m_table_built  = m_table_built_reg;

endmodule

`default_nettype wire
